// File: rtl/core/cmdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdp_pkg
// shared constants for the complex to dB / phase converter
// ----------------------------------------------------------------------------
package cmdp_pkg;

    // sum of squares (Q32.32) and log datapath
    localparam int SQ_W      = 64;
    localparam int MANT_W    = 31;            // Q1.30 mantissa
    localparam int LOG_FRAC  = 16;
    localparam int LOG_W     = 6 + LOG_FRAC;  // integer part is msb position 0..63
    localparam int DB_LAT    = 24;            // pipeline depth of the log path

    localparam logic signed [22:0] LOG_OFFSET = 23'sd2097152;   // 32 in Q.16
    localparam logic signed [26:0] DB_PER_LOG2 = 27'sd50504453; // 10*log10(2) Q2.24

    // cordic datapath: components scaled by 2^16 plus growth headroom
    localparam int XY_W      = 51;
    localparam int Z_W       = 26;
    localparam int ARC_W     = 22;
    localparam logic signed [Z_W-1:0] QUARTER_TURN = 26'sd5898240; // 90 deg, 2^-16 units
    localparam logic signed [17:0]    PHASE_LIMIT  = 18'sd46080;

    // atan(2^-i) in units of 2^-16 degree
    localparam logic [ARC_W-1:0] ARC_TABLE [32] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0
    };

endpackage

// File: rtl/core/cmdp_log_db.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdp_log_db
// pipelined 20*log10|z| from the exact sum of squares, 1/256 dB units
// ----------------------------------------------------------------------------
module cmdp_log_db (
    input  logic               aclk,
    input  logic               ce,
    input  logic signed [31:0] re,
    input  logic signed [31:0] im,
    output logic signed [15:0] db
);
    import cmdp_pkg::*;

    localparam int NSQ = LOG_FRAC;

    logic [31:0]       ar_reg, ai_reg;
    logic [62:0]       sqr_reg, sqi_reg;   // full-scale square reaches 2^62
    logic [SQ_W-1:0]   s3_reg, s4_reg, s5_reg;
    logic [7:0]        nz_reg;
    logic [2:0]        pos_reg [8];
    logic [5:0]        e_reg;
    logic [MANT_W-1:0] m_reg  [0:NSQ];
    logic [LOG_W-1:0]  lq_reg [0:NSQ];
    logic signed [49:0] prod_reg;
    logic signed [15:0] db_reg;

    logic [7:0]        nz_next;
    logic [2:0]        pos_next [8];
    logic [5:0]        e_next;
    logic [SQ_W-1:0]   sh;
    logic signed [22:0] d;
    logic signed [49:0] prod_next;
    logic [49:0]       abs_p;
    logic [17:0]       rmag;
    logic signed [18:0] r;
    logic signed [15:0] db_next;

    // per-byte leading one
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            nz_next[b]  = |s3_reg[8*b +: 8];
            pos_next[b] = 3'd0;
            for (int j = 0; j < 8; j++) begin
                if (s3_reg[8*b + j]) pos_next[b] = 3'(j);
            end
        end
    end

    // highest nonzero byte
    always_comb begin
        e_next = 6'd0;
        for (int b = 0; b < 8; b++) begin
            if (nz_reg[b]) e_next = {3'(b), pos_reg[b]};
        end
    end

    assign sh = s5_reg << (6'd63 - e_reg);

    always_ff @(posedge aclk) begin
        if (ce) begin
            ar_reg  <= re[31] ? 32'(-re) : 32'(re);
            ai_reg  <= im[31] ? 32'(-im) : 32'(im);
            sqr_reg <= 63'(ar_reg) * 63'(ar_reg);
            sqi_reg <= 63'(ai_reg) * 63'(ai_reg);
            s3_reg  <= SQ_W'(sqr_reg) + SQ_W'(sqi_reg);
            s4_reg  <= s3_reg;
            nz_reg  <= nz_next;
            pos_reg <= pos_next;
            s5_reg  <= s4_reg;
            e_reg   <= e_next;
            m_reg[0]  <= sh[63:33];
            lq_reg[0] <= LOG_W'(e_reg);
        end
    end

    // one squaring per stage gives one fraction bit
    for (genvar k = 1; k <= NSQ; k++) begin : g_sq
        logic [61:0] p;
        logic [31:0] q;
        assign p = m_reg[k-1] * m_reg[k-1];
        assign q = p[61:30];
        always_ff @(posedge aclk) begin
            if (ce) begin
                m_reg[k]  <= q[31] ? q[31:1] : q[30:0];
                lq_reg[k] <= {lq_reg[k-1][LOG_W-2:0], q[31]};
            end
        end
    end

    assign d         = $signed({1'b0, lq_reg[NSQ]}) - LOG_OFFSET;
    assign prod_next = d * DB_PER_LOG2;
    assign abs_p     = prod_reg[49] ? 50'(-prod_reg) : 50'(prod_reg);
    assign rmag      = 18'((abs_p + 50'd2147483648) >> 32);
    assign r         = prod_reg[49] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});

    always_comb begin
        if (r > 19'sd32767)       db_next = 16'sd32767;
        else if (r < -19'sd32768) db_next = -16'sd32768;
        else                      db_next = 16'(r);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg <= prod_next;
            db_reg   <= db_next;
        end
    end

    assign db = db_reg;

endmodule

// File: rtl/core/cmdp_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdp_cordic
// quadrant pre-rotation and vectoring cordic, phase in 1/256 degree
// ----------------------------------------------------------------------------
module cmdp_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               aclk,
    input  logic               ce,
    input  logic signed [31:0] re,
    input  logic signed [31:0] im,
    output logic signed [16:0] phase
);
    import cmdp_pkg::*;

    localparam int N = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

    logic signed [XY_W-1:0] x_reg [0:N];
    logic signed [XY_W-1:0] y_reg [0:N];
    logic signed [Z_W-1:0]  z_reg [0:N];
    logic signed [16:0]     phase_reg;

    logic signed [XY_W-1:0] x0, y0;
    logic [Z_W-1:0]         abs_z;
    logic [17:0]            zmag;
    logic signed [18:0]     t;
    logic signed [16:0]     phase_next;

    assign x0 = XY_W'(re) <<< 16;
    assign y0 = XY_W'(im) <<< 16;

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (re[31] && !im[31]) begin
                x_reg[0] <= y0;
                y_reg[0] <= -x0;
                z_reg[0] <= QUARTER_TURN;
            end else if (re[31]) begin
                x_reg[0] <= -y0;
                y_reg[0] <= x0;
                z_reg[0] <= -QUARTER_TURN;
            end else begin
                x_reg[0] <= x0;
                y_reg[0] <= y0;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        logic signed [XY_W-1:0] dx, dy;
        logic signed [Z_W-1:0]  arc;
        assign dx  = y_reg[i] >>> i;
        assign dy  = x_reg[i] >>> i;
        assign arc = $signed({{(Z_W-ARC_W){1'b0}}, ARC_TABLE[i]});
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + arc;
                end else begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - arc;
                end
            end
        end
    end

    assign abs_z = z_reg[N][Z_W-1] ? Z_W'(-z_reg[N]) : Z_W'(z_reg[N]);
    assign zmag  = 18'((abs_z + Z_W'(128)) >> 8);
    assign t     = z_reg[N][Z_W-1] ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});

    always_comb begin
        if (t > 19'(PHASE_LIMIT))       phase_next = 17'(PHASE_LIMIT);
        else if (t < -19'(PHASE_LIMIT)) phase_next = -17'(PHASE_LIMIT);
        else                            phase_next = 17'(t);
    end

    always_ff @(posedge aclk) begin
        if (ce) phase_reg <= phase_next;
    end

    assign phase = phase_reg;

endmodule

// File: rtl/core/complex_to_db_and_phase.sv
`timescale 1ns / 1ps
// alignment: the shorter of the log and cordic paths is padded to the longer, then the output is registered
// throughput: one transaction per cycle while the master side does not stall, set by the single-step pipeline stages
// (one squaring per stage in the log path, one rotation per stage in the cordic)
// a stall on the master side freezes the whole pipeline, nothing is dropped
// reset: synchronous active-low aresetn clears the valid line and m_tvalid
// ----------------------------------------------------------------------------
// complex_to_db_and_phase
// streaming magnitude in dB and four-quadrant phase of complex Q16.16 points
// ----------------------------------------------------------------------------
module complex_to_db_and_phase #(
    parameter int CORDIC_STAGES = 16,
    parameter int SAMPLE_WIDTH  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // real_part[31:0], imag_part[63:32], frequency[95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // level_db[15:0], angle[32:16],
                                   // frequency_out[64:33], zero fill[71:65]
    output logic        m_tuser    // zero_magnitude
);
    import cmdp_pkg::*;

    localparam int IN_BITS = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;
    localparam int NST     = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
    localparam int PH_LAT  = NST + 2;
    localparam int TOT     = (DB_LAT > PH_LAT) ? DB_LAT : PH_LAT;
    localparam int DB_PAD  = TOT - DB_LAT;
    localparam int PH_PAD  = TOT - PH_LAT;

    // whole pipeline advances together unless the output register is held
    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // components as IN_BITS-bit signed samples
    logic signed [IN_BITS-1:0] re_n, im_n;
    logic signed [31:0]        re, im;
    assign re_n = s_tdata[IN_BITS-1:0];
    assign im_n = s_tdata[32 +: IN_BITS];
    assign re   = 32'(re_n);
    assign im   = 32'(im_n);

    logic signed [15:0] db_raw;
    logic signed [16:0] ph_raw;

    cmdp_log_db u_log (
        .aclk (aclk),
        .ce   (ce),
        .re   (re),
        .im   (im),
        .db   (db_raw)
    );

    cmdp_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk  (aclk),
        .ce    (ce),
        .re    (re),
        .im    (im),
        .phase (ph_raw)
    );

    // side band: valid, zero flag and frequency ride alongside the datapath
    logic              vld_reg  [0:TOT];
    logic              zero_reg [0:TOT];
    logic [31:0]       freq_reg [0:TOT];
    logic signed [15:0] db_dly  [0:DB_PAD];
    logic signed [16:0] ph_dly  [0:PH_PAD];

    assign vld_reg[0]  = s_tvalid;
    assign zero_reg[0] = (re == 32'sd0) && (im == 32'sd0);
    assign freq_reg[0] = s_tdata[95:64];
    assign db_dly[0]   = db_raw;
    assign ph_dly[0]   = ph_raw;

    for (genvar k = 1; k <= TOT; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ce) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                zero_reg[k] <= zero_reg[k-1];
                freq_reg[k] <= freq_reg[k-1];
            end
        end
    end

    // align the shorter result path
    for (genvar k = 1; k <= DB_PAD; k++) begin : g_db_pad
        always_ff @(posedge aclk) begin
            if (ce) db_dly[k] <= db_dly[k-1];
        end
    end

    for (genvar k = 1; k <= PH_PAD; k++) begin : g_ph_pad
        always_ff @(posedge aclk) begin
            if (ce) ph_dly[k] <= ph_dly[k-1];
        end
    end

    // output register
    logic              m_tvalid_reg;
    logic [15:0]       db_out_reg;
    logic [16:0]       ph_out_reg;
    logic [31:0]       freq_out_reg;
    logic              zero_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= vld_reg[TOT];
        end
    end

    // zero magnitude forces both results to zero
    always_ff @(posedge aclk) begin
        if (ce) begin
            db_out_reg   <= zero_reg[TOT] ? 16'd0 : db_dly[DB_PAD];
            ph_out_reg   <= zero_reg[TOT] ? 17'd0 : ph_dly[PH_PAD];
            freq_out_reg <= freq_reg[TOT];
            zero_out_reg <= zero_reg[TOT];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, freq_out_reg, ph_out_reg, db_out_reg};
    assign m_tuser  = zero_out_reg;

endmodule
